>>> sv/tprc_pkg.sv
`default_nettype none
package tprc_pkg;

   localparam int NUMBER_OF_TESTS_DEFAULT = 7;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CSR_PEER_ADDRESS   = 8'd0;
   localparam logic [7:0] CSR_BASE_PORT      = 8'd1;
   localparam logic [7:0] CSR_PROBE_SEQUENCE = 8'd2;
   localparam logic [7:0] CSR_MSS_VALUE      = 8'd3;

   localparam logic [15:0] MSS_VALUE_RESET = 16'd265;

   localparam logic [2:0] SYM_NOP       = 3'd0;
   localparam logic [2:0] SYM_MSS       = 3'd1;
   localparam logic [2:0] SYM_WSCALE    = 3'd2;
   localparam logic [2:0] SYM_TIMESTAMP = 3'd3;
   localparam logic [2:0] SYM_END       = 3'd4;

   localparam logic [1:0] ACK_SEQ_PLUS_ONE = 2'd0;
   localparam logic [1:0] ACK_SEQ          = 2'd1;
   localparam logic [1:0] ACK_OTHER        = 2'd2;

   typedef struct packed {
      logic [31:0] peer_address;
      logic [15:0] base_port;
      logic [31:0] probe_sequence;
      logic [15:0] mss_value;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  symbol;
      logic        mss_equal;
      logic        matched;
      logic [2:0]  test_index;
      logic        dont_fragment;
      logic [15:0] window;
      logic [1:0]  ack_class;
      logic [6:0]  flag_bits;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage
`default_nettype wire

>>> sv/tprc_rsp_fifo.sv
`default_nettype none
module tprc_rsp_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  tprc_pkg::push_type    push,
   output logic                  space_ok,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output tprc_pkg::result_type  rsp_result
);
   import tprc_pkg::*;

   result_type           entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   logic [RSP_PTR_W-1:0] wr_next;

   assign pop        = rsp_valid && rsp_ready;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_result = entry_ff[rd_ptr_ff];
   assign space_ok   = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign wr_next    = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2)))
      else $error("Response queue written without room.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("Response queue count out of range.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> (count_ff <= RSP_CNT_W'(2)))
      else $error("Response queue count moved from empty by more than one push.");

endmodule
`default_nettype wire

>>> sv/tprc_parser.sv
`default_nettype none
module tprc_parser #(
   parameter int NUMBER_OF_TESTS = tprc_pkg::NUMBER_OF_TESTS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  tprc_pkg::cfg_type   cfg,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire  [7:0]          in_byte,
   input  wire                 in_eop,
   input  wire                 space_ok,
   output tprc_pkg::push_type  push
);
   import tprc_pkg::*;

   localparam logic [2:0] PH_KIND    = 3'd0;
   localparam logic [2:0] PH_MSS_LEN = 3'd1;
   localparam logic [2:0] PH_MSS_HI  = 3'd2;
   localparam logic [2:0] PH_MSS_LO  = 3'd3;
   localparam logic [2:0] PH_SKIP    = 3'd4;

   localparam logic [7:0] OPT_END       = 8'd0;
   localparam logic [7:0] OPT_NOP       = 8'd1;
   localparam logic [7:0] OPT_MSS       = 8'd2;
   localparam logic [7:0] OPT_WSCALE    = 8'd3;
   localparam logic [7:0] OPT_TIMESTAMP = 8'd8;

   localparam logic [7:0] PROTO_TCP      = 8'd6;
   localparam logic [3:0] WSCALE_SKIP    = 4'd2;
   localparam logic [3:0] TIMESTAMP_SKIP = 4'd9;
   localparam int         DF_BIT_POS     = 6;

   localparam logic [6:0] OFS_FLAGS_FRAG = 7'd6;
   localparam logic [6:0] OFS_PROTOCOL   = 7'd9;
   localparam logic [6:0] OFS_SRC_FIRST  = 7'd12;
   localparam logic [6:0] OFS_SRC_LAST   = 7'd15;
   localparam logic [6:0] OFS_DPORT_HI   = 7'd22;
   localparam logic [6:0] OFS_DPORT_LO   = 7'd23;
   localparam logic [6:0] OFS_ACK_FIRST  = 7'd28;
   localparam logic [6:0] OFS_ACK_LAST   = 7'd31;
   localparam logic [6:0] OFS_DATA_OFS   = 7'd32;
   localparam logic [6:0] OFS_TCP_FLAGS  = 7'd33;
   localparam logic [6:0] OFS_WINDOW_HI  = 7'd34;
   localparam logic [6:0] OFS_WINDOW_LO  = 7'd35;
   localparam logic [6:0] OFS_MIN_LEN    = 7'd39;
   localparam logic [6:0] OFS_OPTIONS    = 7'd40;
   localparam logic [6:0] OFS_IP_HEADER  = 7'd20;
   localparam logic [6:0] OFS_SATURATE   = 7'd127;

   logic        vld_ff;
   logic [7:0]  byte_ff;
   logic        eop_ff;

   logic [6:0]  offset_ff,    offset_in;
   logic        header_ok_ff, header_ok_in;
   logic [15:0] dest_port_ff, dest_port_in;
   logic [31:0] ack_ff,       ack_in;
   logic [3:0]  data_ofs_ff,  data_ofs_in;
   logic [7:0]  flags_ff,     flags_in;
   logic [15:0] window_ff,    window_in;
   logic        df_ff,        df_in;
   logic [2:0]  phase_ff,     phase_in;
   logic [3:0]  skip_ff,      skip_in;
   logic [7:0]  mss_high_ff,  mss_high_in;
   logic        done_ff,      done_in;

   logic        advance;
   logic [7:0]  peer_byte;
   logic [16:0] port_diff;
   logic [6:0]  area_end;
   logic        walk;
   logic        sym_vld;
   logic [2:0]  sym_code;
   logic        sym_eq;
   logic        matched;
   logic [31:0] seq_plus_one;
   result_type  sym_res;
   result_type  sum_res;

   assign advance  = vld_ff && space_ok;
   assign in_ready = !vld_ff || space_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         eop_ff  <= in_eop;
      end
   end

   always_comb begin
      unique case (offset_ff[1:0])
         2'd0:    peer_byte = cfg.peer_address[31:24];
         2'd1:    peer_byte = cfg.peer_address[23:16];
         2'd2:    peer_byte = cfg.peer_address[15:8];
         default: peer_byte = cfg.peer_address[7:0];
      endcase
   end

   always_comb begin
      header_ok_in = header_ok_ff;
      dest_port_in = dest_port_ff;
      ack_in       = ack_ff;
      data_ofs_in  = data_ofs_ff;
      flags_in     = flags_ff;
      window_in    = window_ff;
      df_in        = df_ff;
      port_diff    = {1'b0, dest_port_ff[15:8], byte_ff} - {1'b0, cfg.base_port};
      if (offset_ff == OFS_FLAGS_FRAG) begin
         df_in = byte_ff[DF_BIT_POS];
      end else if (offset_ff == OFS_PROTOCOL) begin
         header_ok_in = (byte_ff == PROTO_TCP);
      end else if (offset_ff >= OFS_SRC_FIRST && offset_ff <= OFS_SRC_LAST) begin
         if (byte_ff != peer_byte) begin
            header_ok_in = 1'b0;
         end
      end else if (offset_ff == OFS_DPORT_HI) begin
         dest_port_in = {byte_ff, 8'd0};
      end else if (offset_ff == OFS_DPORT_LO) begin
         dest_port_in = {dest_port_ff[15:8], byte_ff};
         if (port_diff[16] || port_diff[15:0] >= 16'(NUMBER_OF_TESTS)) begin
            header_ok_in = 1'b0;
         end
      end else if (offset_ff >= OFS_ACK_FIRST && offset_ff <= OFS_ACK_LAST) begin
         ack_in = {ack_ff[23:0], byte_ff};
      end else if (offset_ff == OFS_DATA_OFS) begin
         data_ofs_in = byte_ff[7:4];
      end else if (offset_ff == OFS_TCP_FLAGS) begin
         flags_in = byte_ff;
      end else if (offset_ff == OFS_WINDOW_HI) begin
         window_in = {byte_ff, 8'd0};
      end else if (offset_ff == OFS_WINDOW_LO) begin
         window_in = {window_ff[15:8], byte_ff};
      end
   end

   assign area_end = OFS_IP_HEADER + {1'b0, data_ofs_ff, 2'b00};
   assign walk     = (offset_ff >= OFS_OPTIONS) && (offset_ff < OFS_SATURATE)
                     && header_ok_in && !done_ff;

   always_comb begin
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      mss_high_in = mss_high_ff;
      done_in     = done_ff;
      sym_vld     = 1'b0;
      sym_code    = SYM_NOP;
      sym_eq      = 1'b0;
      if (walk) begin
         unique case (phase_ff)
            PH_KIND: begin
               if (offset_ff < area_end) begin
                  case (byte_ff)
                     OPT_END: begin
                        sym_vld  = 1'b1;
                        sym_code = SYM_END;
                        done_in  = 1'b1;
                     end
                     OPT_NOP: begin
                        sym_vld  = 1'b1;
                        sym_code = SYM_NOP;
                     end
                     OPT_MSS: begin
                        phase_in = PH_MSS_LEN;
                     end
                     OPT_WSCALE: begin
                        sym_vld  = 1'b1;
                        sym_code = SYM_WSCALE;
                        phase_in = PH_SKIP;
                        skip_in  = WSCALE_SKIP;
                     end
                     OPT_TIMESTAMP: begin
                        sym_vld  = 1'b1;
                        sym_code = SYM_TIMESTAMP;
                        phase_in = PH_SKIP;
                        skip_in  = TIMESTAMP_SKIP;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            PH_MSS_LEN: begin
               phase_in = PH_MSS_HI;
            end
            PH_MSS_HI: begin
               mss_high_in = byte_ff;
               phase_in    = PH_MSS_LO;
            end
            PH_MSS_LO: begin
               sym_vld  = 1'b1;
               sym_code = SYM_MSS;
               sym_eq   = ({mss_high_ff, byte_ff} == cfg.mss_value);
               phase_in = PH_KIND;
            end
            default: begin
               if (skip_ff != 4'd0) begin
                  skip_in = skip_ff - 4'd1;
               end
               if (skip_in == 4'd0) begin
                  phase_in = PH_KIND;
               end
            end
         endcase
      end
   end

   assign matched      = header_ok_in && (offset_ff >= OFS_MIN_LEN);
   assign seq_plus_one = cfg.probe_sequence + 32'd1;

   always_comb begin
      sym_res           = '0;
      sym_res.symbol    = sym_code;
      sym_res.mss_equal = sym_eq;
      sym_res.last      = !eop_ff;

      sum_res         = '0;
      sum_res.kind    = 1'b1;
      sum_res.matched = matched;
      sum_res.last    = 1'b1;
      if (matched) begin
         sum_res.test_index    = 3'(dest_port_in - cfg.base_port);
         sum_res.dont_fragment = df_in;
         sum_res.window        = window_in;
         sum_res.flag_bits     = flags_in[6:0];
         if (ack_in == seq_plus_one) begin
            sum_res.ack_class = ACK_SEQ_PLUS_ONE;
         end else if (ack_in == cfg.probe_sequence) begin
            sum_res.ack_class = ACK_SEQ;
         end else begin
            sum_res.ack_class = ACK_OTHER;
         end
      end

      push        = '0;
      push.first  = sym_vld ? sym_res : sum_res;
      push.second = sum_res;
      if (advance) begin
         push.count = 2'({1'b0, sym_vld} + {1'b0, eop_ff});
      end
   end

   assign offset_in = (offset_ff < OFS_SATURATE) ? offset_ff + 7'd1 : offset_ff;

   always_ff @(posedge clock) begin
      if (reset || (advance && eop_ff)) begin
         offset_ff    <= '0;
         header_ok_ff <= 1'b0;
         dest_port_ff <= '0;
         ack_ff       <= '0;
         data_ofs_ff  <= '0;
         flags_ff     <= '0;
         window_ff    <= '0;
         df_ff        <= 1'b0;
         phase_ff     <= PH_KIND;
         skip_ff      <= '0;
         mss_high_ff  <= '0;
         done_ff      <= 1'b0;
      end else if (advance) begin
         offset_ff    <= offset_in;
         header_ok_ff <= header_ok_in;
         dest_port_ff <= dest_port_in;
         ack_ff       <= ack_in;
         data_ofs_ff  <= data_ofs_in;
         flags_ff     <= flags_in;
         window_ff    <= window_in;
         df_ff        <= df_in;
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         mss_high_ff  <= mss_high_in;
         done_ff      <= done_in;
      end
   end

   a_eop_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && eop_ff) |=> (offset_ff == '0 && !header_ok_ff && !done_ff))
      else $error("Packet state not cleared after the final byte.");

   a_offset_steps: assert property (@(posedge clock) disable iff (reset)
      (advance && !eop_ff && offset_ff < OFS_SATURATE)
      |=> (offset_ff == $past(offset_ff) + 7'd1))
      else $error("Byte offset did not advance by one.");

   a_pair_ends_summary: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (eop_ff && push.second.kind && !push.first.kind))
      else $error("Two results from one byte must be a symbol then a summary.");

endmodule
`default_nettype wire

>>> sv/tcp_probe_reply_classifier_core.sv
// A byte accepted on req is registered, then its results are written to the response queue.
// Throughput: one byte per cycle while the queue has room; a symbol-and-summary byte pushes
// two results at once, drained by a four-entry response queue behind the option decoder.
// Reset (synchronous, active high) returns the registers to their reset values,
// empties the response queue and clears all per-packet parsing state.
`default_nettype none
module tcp_probe_reply_classifier_core #(
   parameter int NUMBER_OF_TESTS = tprc_pkg::NUMBER_OF_TESTS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // data_byte[7:0]
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // symbol[2:0], mss_equal[3], matched[4], test_index[7:5],
                                    // dont_fragment[8], window[24:9], ack_class[26:25],
                                    // flag_bits[33:27], zero[39:34]
   output logic        rsp_tuser,   // kind[0]
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_index,
   input  wire  [31:0] csr_data
);
   import tprc_pkg::*;

   cfg_type    cfg_ff;
   push_type   push;
   logic       space_ok;
   result_type rsp_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peer_address   <= '0;
         cfg_ff.base_port      <= '0;
         cfg_ff.probe_sequence <= '0;
         cfg_ff.mss_value      <= MSS_VALUE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PEER_ADDRESS:   cfg_ff.peer_address   <= csr_data;
            CSR_BASE_PORT:      cfg_ff.base_port      <= csr_data[15:0];
            CSR_PROBE_SEQUENCE: cfg_ff.probe_sequence <= csr_data;
            CSR_MSS_VALUE:      cfg_ff.mss_value      <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   tprc_parser #(
      .NUMBER_OF_TESTS(NUMBER_OF_TESTS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_byte (req_tdata),
      .in_eop  (req_tlast),
      .space_ok(space_ok),
      .push    (push)
   );

   tprc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_result(rsp_result)
   );

   assign rsp_tuser = rsp_result.kind;
   assign rsp_tlast = rsp_result.last;
   assign rsp_tdata = {6'd0,
                       rsp_result.flag_bits,
                       rsp_result.ack_class,
                       rsp_result.window,
                       rsp_result.dont_fragment,
                       rsp_result.test_index,
                       rsp_result.matched,
                       rsp_result.mss_equal,
                       rsp_result.symbol};

endmodule
`default_nettype wire
